### hw/rtl/stf_pkg.sv
// Shared types, constants and register indexes for the sine tone generator.
// Used by every module of the block; depends on nothing.
package stf_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int LENGTH_BITS_DEF    = 20;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_SCALE = 2'd3;

    localparam logic        ENABLE_RST      = 1'b1;
    localparam logic [15:0] FADE_LENGTH_RST = 16'd480;
    localparam logic [15:0] FADE_STEP_RST   = 16'd137;
    localparam logic [31:0] PHASE_SCALE_RST = 32'd22906492;

    // Q30 coefficients of the quarter-wave odd polynomial
    localparam logic [31:0] COEF_A1 = 32'd1686629713;
    localparam logic [31:0] COEF_A3 = 32'd693598671;
    localparam logic [31:0] COEF_A5 = 32'd85569278;
    localparam logic [31:0] COEF_A7 = 32'd5027044;

    localparam logic [16:0] UNITY      = 17'h10000;
    localparam logic [31:0] ROUND_HALF = 32'd16384;
    localparam logic [14:0] SINE_MAX   = 15'h7fff;

    typedef struct packed {
        logic        mode;
        logic [15:0] tone_frequency;
        logic [19:0] tone_length;
        logic [16:0] tone_volume;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               playing;
    } out_item_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] fade_length;
        logic [15:0] fade_step;
        logic [31:0] phase_scale;
    } cfg_t;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

endpackage

### hw/rtl/sine_tone_with_fade_top.sv
// Top level of the sine tone generator with linear fade envelope.
// Holds configuration registers and the result register; depends on stf_pkg, stf_core.
//
//   port group   | dir | handshake          | payload
//   s_           | in  | s_valid / s_ready  | s_item  (stf_pkg::in_item_t)
//   m_           | out | m_valid / m_ready  | m_item  (stf_pkg::out_item_t)
//   cfg_         | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// A tick with a tone playing runs eight products in turn through the one shared
// 32x17 multiplier before the next item is accepted. An idle tick goes straight to
// the result; a start passes the START and LOAD states, or is ignored in IDLE.
// s_ready is low while an item is in work and while a result waits for room.
// aresetn is synchronous: it stops any tone and restores register defaults.
module sine_tone_with_fade_top #(
    parameter int SINE_ADDR_BITS = stf_pkg::SINE_ADDR_BITS_DEF,
    parameter int LENGTH_BITS    = stf_pkg::LENGTH_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  stf_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output stf_pkg::out_item_t                m_item,
    input  logic                              cfg_wr_en,
    input  logic [stf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [stf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    stf_pkg::cfg_t      cfg_reg, cfg_next;
    logic               m_valid_reg, m_valid_next;
    stf_pkg::out_item_t m_item_reg;
    logic               res_valid;
    logic               res_ready;
    stf_pkg::out_item_t res_item;

    stf_core #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .LENGTH_BITS    (LENGTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                stf_pkg::CFG_ENABLE:      cfg_next.enable      = cfg_wdata[0];
                stf_pkg::CFG_FADE_LENGTH: cfg_next.fade_length = cfg_wdata[15:0];
                stf_pkg::CFG_FADE_STEP:   cfg_next.fade_step   = cfg_wdata[15:0];
                stf_pkg::CFG_PHASE_SCALE: cfg_next.phase_scale = cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable      <= stf_pkg::ENABLE_RST;
            cfg_reg.fade_length <= stf_pkg::FADE_LENGTH_RST;
            cfg_reg.fade_step   <= stf_pkg::FADE_STEP_RST;
            cfg_reg.phase_scale <= stf_pkg::PHASE_SCALE_RST;
            m_valid_reg         <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_item_reg)))
        else $error("pending result item overwritten");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("input taken while a result is pending in the core");

    a_cfg_enable_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_index == stf_pkg::CFG_ENABLE) |=> (cfg_reg.enable == $past(cfg_wdata[0])))
        else $error("enable register not written");

endmodule

### hw/rtl/stf_mul.sv
// Shared 32x17 unsigned multiplier with a registered product.
// Depends on stf_pkg for operand widths.
module stf_mul (
    input  logic                         aclk,
    input  logic [stf_pkg::MUL_A_W-1:0]  mul_a,
    input  logic [stf_pkg::MUL_B_W-1:0]  mul_b,
    output logic [stf_pkg::MUL_P_W-1:0]  prod_reg
);

    logic [stf_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = stf_pkg::MUL_P_W'(mul_a) * stf_pkg::MUL_P_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

### hw/rtl/stf_core.sv
// Tone state and sequencer: drives the shared multiplier through phase step,
// sine polynomial, envelope and volume. Depends on stf_pkg and stf_mul.
module stf_core #(
    parameter int SINE_ADDR_BITS = stf_pkg::SINE_ADDR_BITS_DEF,
    parameter int LENGTH_BITS    = stf_pkg::LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  stf_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  stf_pkg::in_item_t   in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output stf_pkg::out_item_t  res_item
);

    localparam int QTR_BITS = SINE_ADDR_BITS - 2;
    localparam int CMP_W    = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    typedef enum logic [12:0] {
        S_IDLE  = 13'h0001,
        S_START = 13'h0002,
        S_LOAD  = 13'h0004,
        S_TICK  = 13'h0008,
        S_P7    = 13'h0010,
        S_P5    = 13'h0020,
        S_P3    = 13'h0040,
        S_P1    = 13'h0080,
        S_RND   = 13'h0100,
        S_ENV   = 13'h0200,
        S_SE    = 13'h0400,
        S_GAIN  = 13'h0800,
        S_EMIT  = 13'h1000
    } state_t;

    state_t                      state_reg, state_next;
    logic                        active_reg, active_next;
    stf_pkg::in_item_t           item_reg;
    logic [31:0]                 phase_acc_reg;
    logic [31:0]                 phase_step_reg;
    logic [LENGTH_BITS-1:0]      index_reg;
    logic [LENGTH_BITS-1:0]      left_reg;
    logic [16:0]                 gain_reg;
    logic [16:0]                 u_reg;
    logic [16:0]                 u2_reg;
    logic                        neg_reg;
    logic                        fin_reg;
    logic [15:0]                 env_op_reg;
    logic                        env_full_reg;
    logic [14:0]                 sine_reg;
    stf_pkg::out_item_t          res_reg;

    logic [stf_pkg::MUL_A_W-1:0] mul_a;
    logic [stf_pkg::MUL_B_W-1:0] mul_b;
    logic [stf_pkg::MUL_P_W-1:0] prod;

    logic                        accept;
    logic                        start_ok;
    logic [16:0]                 u_raw;
    logic [16:0]                 u_comb;
    logic                        idx_in_fade;
    logic                        left_in_fade;
    logic [LENGTH_BITS-1:0]      left_dec;
    logic [31:0]                 prod_hi;
    logic [31:0]                 s_rnd;
    logic [14:0]                 sine_q;
    logic [16:0]                 env_val;
    logic [15:0]                 mag;
    logic [16:0]                 vol_sat;

    stf_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_EMIT);
    assign res_item  = res_reg;

    assign start_ok = cfg.enable && (LENGTH_BITS'(in_item.tone_length) != '0);

    assign u_raw  = 17'(phase_acc_reg[29 -: QTR_BITS]) << (16 - QTR_BITS);
    assign u_comb = phase_acc_reg[30] ? (stf_pkg::UNITY - u_raw) : u_raw;

    assign idx_in_fade  = CMP_W'(index_reg) < CMP_W'(cfg.fade_length);
    assign left_in_fade = CMP_W'(left_reg) < CMP_W'(cfg.fade_length);
    assign left_dec     = left_reg - 1'b1;

    assign prod_hi = prod[47:16];
    assign s_rnd   = prod_hi + stf_pkg::ROUND_HALF;
    assign sine_q  = (s_rnd[31:30] != 2'b00) ? stf_pkg::SINE_MAX : s_rnd[29:15];
    assign env_val = (env_full_reg || (prod[47:0] > 48'(stf_pkg::UNITY)))
                     ? stf_pkg::UNITY : prod[16:0];
    assign mag     = prod[47:32];
    assign vol_sat = (item_reg.tone_volume > stf_pkg::UNITY)
                     ? stf_pkg::UNITY : item_reg.tone_volume;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_START: begin
                mul_a = cfg.phase_scale;
                mul_b = 17'(item_reg.tone_frequency);
            end
            S_TICK: begin
                mul_a = 32'(u_comb);
                mul_b = u_comb;
            end
            S_P7: begin
                mul_a = stf_pkg::COEF_A7;
                mul_b = prod[32:16];
            end
            S_P5: begin
                mul_a = stf_pkg::COEF_A5 - prod_hi;
                mul_b = u2_reg;
            end
            S_P3: begin
                mul_a = stf_pkg::COEF_A3 - prod_hi;
                mul_b = u2_reg;
            end
            S_P1: begin
                mul_a = stf_pkg::COEF_A1 - prod_hi;
                mul_b = u_reg;
            end
            S_RND: begin
                mul_a = 32'(env_op_reg);
                mul_b = 17'(cfg.fade_step);
            end
            S_ENV: begin
                mul_a = 32'(sine_reg);
                mul_b = env_val;
            end
            S_SE: begin
                mul_a = prod[31:0];
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_item.mode == stf_pkg::MODE_START) begin
                        state_next = start_ok ? S_START : S_IDLE;
                    end else begin
                        state_next = active_reg ? S_TICK : S_EMIT;
                    end
                end
            end
            S_START: state_next = S_LOAD;
            S_LOAD: begin
                active_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_TICK: begin
                if (left_dec == '0) begin
                    active_next = 1'b0;
                end
                state_next = S_P7;
            end
            S_P7:   state_next = S_P5;
            S_P5:   state_next = S_P3;
            S_P3:   state_next = S_P1;
            S_P1:   state_next = S_RND;
            S_RND:  state_next = S_ENV;
            S_ENV:  state_next = S_SE;
            S_SE:   state_next = S_GAIN;
            S_GAIN: state_next = S_EMIT;
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
            if (in_item.mode == stf_pkg::MODE_TICK && !active_reg) begin
                res_reg <= '0;
            end
        end
        case (state_reg)
            S_LOAD: begin
                phase_step_reg <= prod[39:8];
                phase_acc_reg  <= '0;
                index_reg      <= '0;
                left_reg       <= LENGTH_BITS'(item_reg.tone_length);
                gain_reg       <= vol_sat;
            end
            S_TICK: begin
                u_reg         <= u_comb;
                neg_reg       <= phase_acc_reg[31];
                env_op_reg    <= idx_in_fade ? 16'(index_reg) : 16'(left_reg);
                env_full_reg  <= !idx_in_fade && !left_in_fade;
                fin_reg       <= (left_dec == '0);
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
                index_reg     <= index_reg + 1'b1;
                left_reg      <= left_dec;
            end
            S_P7: u2_reg <= prod[32:16];
            S_RND: sine_reg <= sine_q;
            S_GAIN: begin
                res_reg.sample  <= neg_reg ? (16'sd0 - $signed(mag)) : $signed(mag);
                res_reg.last    <= fin_reg;
                res_reg.playing <= 1'b1;
            end
            default: ;
        endcase
    end

    a_tick_needs_tone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |-> active_reg)
        else $error("tick sequence started with no tone playing");

    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> (fin_reg && $past(state_reg == S_TICK)))
        else $error("tone ended without a final sample");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GAIN) |-> (prod[48:47] == 2'b00))
        else $error("scaled magnitude exceeds 15 bits");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_item.playing) |-> (res_item.sample == '0 && !res_item.last))
        else $error("idle item is not silent");

endmodule

### test/sine_tone_with_fade_top_tb.sv
// Self-checking testbench for sine_tone_with_fade_top: directed and random tone traffic with
// a built-in predictor of the phase accumulator, quarter-wave sine and fade envelope.
// Depends on stf_pkg and the sine_tone_with_fade_top RTL.
module sine_tone_with_fade_top_tb;

    localparam int ADDR_BITS     = stf_pkg::SINE_ADDR_BITS_DEF;
    localparam int QTR_BITS      = ADDR_BITS - 2;
    localparam int LEN_BITS      = stf_pkg::LENGTH_BITS_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [63:0] FULL_SCALE = 64'd65536;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    stf_pkg::in_item_t               s_item    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    stf_pkg::out_item_t              m_item;
    logic                            cfg_wr_en = 1'b0;
    logic [stf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [stf_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int send_idle_pct  = 12;
    int recv_stall_pct = 45;
    int fail_count     = 0;
    int cycle_count    = 0;

    // register copies
    logic        reg_enable      = stf_pkg::ENABLE_RST;
    logic [15:0] reg_fade_len    = stf_pkg::FADE_LENGTH_RST;
    logic [15:0] reg_fade_step   = stf_pkg::FADE_STEP_RST;
    logic [31:0] reg_phase_scale = stf_pkg::PHASE_SCALE_RST;

    // tone state
    logic [31:0]         tone_phase = '0;
    logic [31:0]         tone_step  = '0;
    logic [LEN_BITS-1:0] tone_index = '0;
    logic [LEN_BITS-1:0] tone_left  = '0;
    logic [16:0]         tone_gain  = '0;
    logic                tone_on    = 1'b0;

    stf_pkg::out_item_t pending_samples[$];

    sine_tone_with_fade_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Q15 magnitude of a quarter sine, u in Q16 over [0, 1]
    function automatic logic [15:0] sine_quarter_q15(logic [63:0] u);
        logic [63:0] u2, t, s;
        u2 = (u * u) >> 16;
        t  = stf_pkg::COEF_A5 - ((stf_pkg::COEF_A7 * u2) >> 16);
        t  = stf_pkg::COEF_A3 - ((t * u2) >> 16);
        t  = stf_pkg::COEF_A1 - ((t * u2) >> 16);
        s  = (t * u) >> 16;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

    task automatic predict_tone_item(stf_pkg::in_item_t it);
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           quad;
        logic [63:0]          u, env, mag;
        stf_pkg::out_item_t   want;
        if (it.mode == stf_pkg::MODE_START) begin
            if (reg_enable && it.tone_length != '0) begin
                tone_step  = 32'((64'(it.tone_frequency) * 64'(reg_phase_scale)) >> 8);
                tone_phase = '0;
                tone_index = '0;
                tone_left  = it.tone_length;
                tone_gain  = (it.tone_volume > stf_pkg::UNITY) ? stf_pkg::UNITY
                                                               : it.tone_volume;
                tone_on    = 1'b1;
            end
        end else if (!tone_on) begin
            want = '0;
            pending_samples.push_back(want);
        end else begin
            addr = tone_phase[31 -: ADDR_BITS];
            quad = addr[ADDR_BITS-1 -: 2];
            u    = 64'(addr[QTR_BITS-1:0]) << (16 - QTR_BITS);
            if (quad[0]) begin
                u = FULL_SCALE - u;
            end
            if (tone_index < reg_fade_len) begin
                env = 64'(tone_index) * 64'(reg_fade_step);
            end else if (tone_left < reg_fade_len) begin
                env = 64'(tone_left) * 64'(reg_fade_step);
            end else begin
                env = FULL_SCALE;
            end
            if (env > FULL_SCALE) begin
                env = FULL_SCALE;
            end
            mag = (64'(sine_quarter_q15(u)) * env * 64'(tone_gain)) >> 32;
            if (quad[1]) begin
                mag = 64'h10000 - mag;
            end
            tone_phase   = tone_phase + tone_step;
            tone_index   = tone_index + 1'b1;
            tone_left    = tone_left - 1'b1;
            want.sample  = mag[15:0];
            want.last    = (tone_left == '0);
            want.playing = 1'b1;
            if (want.last) begin
                tone_on = 1'b0;
            end
            pending_samples.push_back(want);
        end
    endtask

    always @(posedge aclk) begin : result_check
        stf_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result: sample %0d last %0b playing %0b",
                       $signed(m_item.sample), m_item.last, m_item.playing);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_item.sample !== want.sample) begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           $signed(want.sample), $signed(m_item.sample));
                    fail_count++;
                end
                if (m_item.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, m_item.last);
                    fail_count++;
                end
                if (m_item.playing !== want.playing) begin
                    $error("playing mismatch: expected %0b, actual %0b",
                           want.playing, m_item.playing);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_item(stf_pkg::in_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_tone_item(it);
    endtask

    task automatic send_start(logic [15:0] freq, logic [19:0] len, logic [16:0] vol);
        stf_pkg::in_item_t it;
        it.mode           = stf_pkg::MODE_START;
        it.tone_frequency = freq;
        it.tone_length    = len;
        it.tone_volume    = vol;
        push_item(it);
    endtask

    task automatic send_ticks(int n);
        stf_pkg::in_item_t it;
        repeat (n) begin
            it.mode           = stf_pkg::MODE_TICK;
            it.tone_frequency = 16'($urandom);
            it.tone_length    = 20'($urandom);
            it.tone_volume    = 17'($urandom);
            push_item(it);
        end
    endtask

    // drop valid, drain expected samples, then let a trailing start finish
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [stf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [stf_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            stf_pkg::CFG_ENABLE:      reg_enable      = data[0];
            stf_pkg::CFG_FADE_LENGTH: reg_fade_len    = data[15:0];
            stf_pkg::CFG_FADE_STEP:   reg_fade_step   = data[15:0];
            stf_pkg::CFG_PHASE_SCALE: reg_phase_scale = data;
            default: ;
        endcase
    endtask

    task automatic shuffle_registers();
        int fade_len, fade_stp, pick;
        settle();
        pick = $urandom_range(99);
        if (pick < 20) begin
            fade_len = 0;
        end else if (pick < 75) begin
            fade_len = $urandom_range(1, 24);
        end else if (pick < 90) begin
            fade_len = $urandom_range(25, 200);
        end else begin
            fade_len = $urandom_range(0, 65535);
        end
        if (fade_len != 0 && $urandom_range(99) < 75) begin
            fade_stp = 65536 / fade_len;
            if (fade_stp > 65535) begin
                fade_stp = 65535;
            end
        end else begin
            fade_stp = $urandom_range(0, 65535);
        end
        write_reg(stf_pkg::CFG_FADE_LENGTH, 32'(fade_len));
        write_reg(stf_pkg::CFG_FADE_STEP, 32'(fade_stp));
        write_reg(stf_pkg::CFG_PHASE_SCALE,
                  ($urandom_range(99) < 50) ? stf_pkg::PHASE_SCALE_RST : $urandom);
        write_reg(stf_pkg::CFG_ENABLE, 32'($urandom_range(99) >= 8));
    endtask

    task automatic play_random_tones(int budget);
        int sent, len, ticks, pick;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_start(16'($urandom), '0, 17'($urandom));
            end else if (pick < 12) begin
                send_ticks(1);
                sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    len = $urandom_range(1, 40);
                end else if (pick < 95) begin
                    len = $urandom_range(41, 160);
                end else begin
                    len = $urandom_range(1, 20'hFFFFF);
                end
                send_start(16'($urandom), 20'(len),
                           ($urandom_range(99) < 80) ? 17'($urandom_range(0, 65536))
                                                     : 17'($urandom));
                ticks = (len > 160) ? $urandom_range(1, 40) : len + $urandom_range(0, 2);
                if ($urandom_range(99) < 15) begin
                    ticks = $urandom_range(0, ticks);
                end
                send_ticks(ticks);
                sent += 1 + ticks;
            end
        end
    endtask

    task automatic test_idle_tick();
        send_ticks(1);
    endtask

    task automatic test_tone_extremes();
        send_start(16'hFFFF, 20'd3, 17'h1FFFF);     // volume saturates
        send_ticks(4);                              // last on third, then idle
        send_start(16'h0000, 20'd1, 17'd0);
        send_ticks(1);
    endtask

    task automatic test_start_rules();
        send_start(16'd1000, 20'd5, stf_pkg::UNITY);
        send_ticks(1);
        send_start(16'd2000, 20'd0, stf_pkg::UNITY);  // zero length: ignored
        send_ticks(1);
        send_start(16'd440, 20'd2, 17'd32768);      // replaces the running tone
        send_ticks(2);
    endtask

    task automatic test_disable_mid_tone();
        send_start(16'd3000, 20'd3, stf_pkg::UNITY);
        send_ticks(1);
        settle();
        write_reg(stf_pkg::CFG_ENABLE, 32'd0);
        send_start(16'd500, 20'd9, stf_pkg::UNITY);   // ignored, old tone runs out
        send_ticks(2);
        settle();
        write_reg(stf_pkg::CFG_ENABLE, 32'd1);
    endtask

    task automatic test_fade_and_phase_registers();
        settle();
        write_reg(stf_pkg::CFG_FADE_LENGTH, 32'd0);
        write_reg(stf_pkg::CFG_FADE_STEP, 32'hFFFF);
        write_reg(stf_pkg::CFG_PHASE_SCALE, 32'hFFFF_FFFF);
        send_start(16'hFFFF, 20'd2, stf_pkg::UNITY);
        send_ticks(2);
        settle();
        write_reg(stf_pkg::CFG_FADE_LENGTH, 32'hFFFF);    // envelope saturates
        write_reg(stf_pkg::CFG_PHASE_SCALE, 32'd0);
        send_start(16'd1234, 20'hFFFFF, stf_pkg::UNITY);
        send_ticks(3);
        settle();
        write_reg(stf_pkg::CFG_FADE_LENGTH, 32'(stf_pkg::FADE_LENGTH_RST));
        write_reg(stf_pkg::CFG_FADE_STEP, 32'(stf_pkg::FADE_STEP_RST));
        write_reg(stf_pkg::CFG_PHASE_SCALE, stf_pkg::PHASE_SCALE_RST);
    endtask

    task automatic test_random_traffic();
        send_idle_pct  = 12;
        recv_stall_pct = 45;
        repeat (3) begin
            shuffle_registers();
            play_random_tones(45);
        end
        send_idle_pct  = 45;
        recv_stall_pct = 12;
        repeat (3) begin
            shuffle_registers();
            play_random_tones(45);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) begin
            shuffle_registers();
            play_random_tones(45);
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_tick();
        test_tone_extremes();
        test_start_rules();
        test_disable_mid_tone();
        test_fade_and_phase_registers();
        test_random_traffic();
        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sine_tone_with_fade_top.f
hw/rtl/stf_pkg.sv
hw/rtl/stf_mul.sv
hw/rtl/stf_core.sv
hw/rtl/sine_tone_with_fade_top.sv
test/sine_tone_with_fade_top_tb.sv
